// ----- rtl/core/ccp_pkg.sv -----
package ccp_pkg;

   // field widths
   localparam int unsigned COEF_W = 12;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CSR_W  = 4;
   localparam int unsigned CODE_W = 11;
   localparam int unsigned MULT_W = 21;
   localparam int unsigned PROD_W = COEF_W + MULT_W;

   // scaled reciprocal of q, 2^32 / 3329 rounded
   localparam logic [MULT_W-1:0] COMPRESS_MULT = 21'd1290167;

   // code width register
   localparam logic [CSR_W-1:0] CODE_BITS_RESET = 4'd10;
   localparam logic [CSR_W-1:0] CODE_BITS_WIDE  = 4'd11;
   localparam logic [4:0]       D_NARROW        = 5'd10;
   localparam logic [4:0]       D_WIDE          = 5'd11;

   // one output byte with its flags
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              end_of_poly;
      logic              last_of_run;
   } rsp_entry_type;

   // compressed code handed to the packer
   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic              wide;
   } code_type;

   // up to two bytes written into the output queue per cycle
   typedef struct packed {
      logic          push0;
      logic          push1;
      rsp_entry_type entry0;
      rsp_entry_type entry1;
   } push_type;

endpackage

// ----- rtl/core/ccp_channels.sv -----
interface ccp_req_if;
   import ccp_pkg::*;
   logic              valid;
   logic              ready;
   logic [COEF_W-1:0] coefficient;
   modport source (output valid, coefficient, input ready);
   modport sink   (input valid, coefficient, output ready);
endinterface

interface ccp_rsp_if;
   import ccp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              end_of_poly;
   logic              last_of_run;
   modport source (output valid, out_byte, end_of_poly, last_of_run, input ready);
   modport sink   (input valid, out_byte, end_of_poly, last_of_run, output ready);
endinterface

interface ccp_csr_if;
   import ccp_pkg::*;
   logic             valid;
   logic             ready;
   logic [CSR_W-1:0] code_bits;
   modport source (output valid, code_bits, input ready);
   modport sink   (input valid, code_bits, output ready);
endinterface

// ----- rtl/core/ccp_compress.sv -----
module ccp_compress (
   input  logic               clock,
   input  logic               reset,
   ccp_req_if.sink            req,
   input  logic               code_wide,
   input  logic               code_ready,
   output ccp_pkg::code_type  code_out
);
   import ccp_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [COEF_W-1:0] coef_ff, coef_in;
   logic              s2_valid_ff, s2_valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              wide_ff, wide_in;

   logic              s2_move;
   logic              s1_ready;
   logic [PROD_W-1:0] product;
   logic [15:0]       t_val;
   logic [15:0]       t_d10;
   logic [15:0]       t_d11;

   // stage handshake: each stage loads when it is empty or drains this cycle
   assign s2_move   = !s2_valid_ff || code_ready;
   assign s1_ready  = !s1_valid_ff || s2_move;
   assign req.ready = s1_ready;

   // input stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      coef_in     = coef_ff;
      if (s1_ready) begin
         s1_valid_in = req.valid;
         coef_in     = req.coefficient;
      end
   end

   // compress: t = bits 16..31 of x * mult, then round to d bits
   assign product = PROD_W'(coef_ff) * PROD_W'(COMPRESS_MULT);
   assign t_val   = product[31:16];
   assign t_d10   = t_val + 16'd32;
   assign t_d11   = t_val + 16'd16;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      code_in     = code_ff;
      wide_in     = wide_ff;
      if (s2_move) begin
         s2_valid_in = s1_valid_ff;
         wide_in     = code_wide;
         code_in     = code_wide ? t_d11[15:5] : {1'b0, t_d10[15:6]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      coef_ff <= coef_in;
      code_ff <= code_in;
      wide_ff <= wide_in;
   end

   assign code_out.valid = s2_valid_ff;
   assign code_out.code  = code_ff;
   assign code_out.wide  = wide_ff;

endmodule

// ----- rtl/core/ccp_packer.sv -----
module ccp_packer #(
   parameter int unsigned COEFFS_PER_POLY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  ccp_pkg::code_type  code_in,
   input  logic               space_ok,
   output logic               code_ready,
   output ccp_pkg::push_type  push
);
   import ccp_pkg::*;

   localparam int unsigned IDX_W = $clog2(COEFFS_PER_POLY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COEFFS_PER_POLY - 1);

   logic [6:0]       acc_ff, acc_in;
   logic [2:0]       held_ff, held_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic             take;
   logic             defer;
   logic             last;
   logic [6:0]       base_acc;
   logic [2:0]       base_held;
   logic [4:0]       d_bits;
   logic [17:0]      merged;
   logic [4:0]       total;
   logic             two_full;
   logic [4:0]       rem_held;
   logic [6:0]       rem_acc;
   rsp_entry_type    e0, e1;
   logic             n_two;

   assign code_ready = space_ok;
   assign take       = code_in.valid && space_ok;

   // a padded byte left over from the previous polynomial goes out first
   assign defer     = (idx_ff == '0) && (held_ff != 3'd0);
   assign last      = !defer && (idx_ff == LAST_IDX);
   assign base_acc  = defer ? 7'd0 : acc_ff;
   assign base_held = defer ? 3'd0 : held_ff;
   assign d_bits    = code_in.wide ? D_WIDE : D_NARROW;

   // merge the code above the held bits
   assign merged   = 18'(base_acc) | (18'(code_in.code) << base_held);
   assign total    = 5'(base_held) + d_bits;
   assign two_full = total >= 5'd16;
   assign rem_held = two_full ? total - 5'd16 : total - 5'd8;
   assign rem_acc  = two_full ? {5'd0, merged[17:16]} : merged[14:8];

   // byte selection and flags
   always_comb begin
      e0      = '0;
      e1      = '0;
      n_two   = 1'b0;
      acc_in  = acc_ff;
      held_in = held_ff;
      idx_in  = idx_ff;
      e0.out_byte = merged[7:0];
      e1.out_byte = merged[15:8];
      if (defer) begin
         e0.out_byte    = {1'b0, acc_ff};
         e0.end_of_poly = 1'b1;
         e1.out_byte    = merged[7:0];
         e1.last_of_run = 1'b1;
         n_two          = 1'b1;
      end else if (!two_full) begin
         if (last) begin
            // one full byte, the rest padded into a final byte
            e1.out_byte    = {1'b0, rem_acc};
            e1.end_of_poly = 1'b1;
            e1.last_of_run = 1'b1;
            n_two          = 1'b1;
         end else begin
            e0.last_of_run = 1'b1;
         end
      end else begin
         e1.last_of_run = 1'b1;
         e1.end_of_poly = last && (rem_held == 5'd0);
         n_two          = 1'b1;
      end

      if (take) begin
         if (last && !two_full) begin
            acc_in  = 7'd0;
            held_in = 3'd0;
         end else begin
            acc_in  = rem_acc;
            held_in = rem_held[2:0];
         end
         idx_in = last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 7'd0;
         held_ff <= 3'd0;
         idx_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
         idx_ff  <= idx_in;
      end
   end

   assign push.push0  = take;
   assign push.push1  = take && n_two;
   assign push.entry0 = e0;
   assign push.entry1 = e1;

endmodule

// ----- rtl/core/ccp_out_fifo.sv -----
module ccp_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  ccp_pkg::push_type push,
   output logic              space_ok,
   ccp_rsp_if.source         rsp
);
   import ccp_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rsp_entry_type      entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_next;
   logic               pop;
   rsp_entry_type      head;

   assign wr_next  = wr_ptr_ff + PTR_W'(1);
   assign pop      = rsp.valid && rsp.ready;
   assign space_ok = count_ff <= CNT_W'(DEPTH - 2);

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.push0) + PTR_W'(push.push1);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // byte storage, two writes per cycle at most
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (push.push0 && (wr_ptr_ff == PTR_W'(i))) begin
            entries_ff[i] <= push.entry0;
         end else if (push.push1 && (wr_next == PTR_W'(i))) begin
            entries_ff[i] <= push.entry1;
         end
      end
   end

   assign head            = entries_ff[rd_ptr_ff];
   assign rsp.valid       = count_ff != '0;
   assign rsp.out_byte    = head.out_byte;
   assign rsp.end_of_poly = head.end_of_poly;
   assign rsp.last_of_run = head.last_of_run;

endmodule

// ----- rtl/core/coeff_compress_pack.sv -----
// Path: a transferred coefficient is registered in the input stage, then in the
// code stage; the packer then writes its bytes into the output queue, which drives rsp.
// Throughput: one coefficient per cycle into the pipeline while the output queue
// has space; the sustained rate is set by the one-byte result port.
// Reset (synchronous): clears the pipeline, packer state, index, queue, and
// sets code_bits to 10.
module coeff_compress_pack #(
   parameter int unsigned COEFFS_PER_POLY = 256
) (
   input  logic      clock,
   input  logic      reset,
   ccp_req_if.sink   req,
   ccp_rsp_if.source rsp,
   ccp_csr_if.sink   csr
);
   import ccp_pkg::*;

   logic [CSR_W-1:0] code_bits_ff, code_bits_in;
   logic             code_wide;
   logic             code_ready;
   logic             space_ok;
   code_type         code_s2;
   push_type         push;

   // code width register, always writable
   assign csr.ready    = 1'b1;
   assign code_bits_in = (csr.valid && csr.ready) ? csr.code_bits : code_bits_ff;
   assign code_wide    = code_bits_ff >= CODE_BITS_WIDE;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_bits_ff <= CODE_BITS_RESET;
      end else begin
         code_bits_ff <= code_bits_in;
      end
   end

   ccp_compress u_compress (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .code_wide  (code_wide),
      .code_ready (code_ready),
      .code_out   (code_s2)
   );

   ccp_packer #(
      .COEFFS_PER_POLY (COEFFS_PER_POLY)
   ) u_packer (
      .clock      (clock),
      .reset      (reset),
      .code_in    (code_s2),
      .space_ok   (space_ok),
      .code_ready (code_ready),
      .push       (push)
   );

   ccp_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp)
   );

endmodule

// ----- rtl/core/ccp_checker.sv -----
module ccp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ccp_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                       rsp_end_of_poly,
   input logic                       rsp_last_of_run
);

   // queue is empty straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_end_of_poly) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // with nothing queued the input side must take a coefficient
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output queue");

   // both bytes of one coefficient are queued together, second closes the run
   a_run_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run)
      else $error("run not closed by following byte");

endmodule

bind coeff_compress_pack ccp_checker u_ccp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_out_byte    (rsp.out_byte),
   .rsp_end_of_poly (rsp.end_of_poly),
   .rsp_last_of_run (rsp.last_of_run)
);
